// ----- src/bpa_pkg.sv -----
// Shared types and constants for the buddy page allocator.
package bpa_pkg;

    localparam int PAGE_SHIFT   = 12;
    localparam int REGION_SHIFT = 20;
    localparam int TOP_ORDER    = REGION_SHIFT - PAGE_SHIFT;
    localparam int NPAGES       = 1 << TOP_ORDER;
    localparam int PAGE_W       = TOP_ORDER;
    localparam int ORD_W        = 4;

    typedef enum logic [1:0] {
        KIND_NONE = 2'd0,
        KIND_FREE = 2'd1,
        KIND_USED = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NO_SPACE  = 2'd1,
        ST_TOO_LARGE = 2'd2,
        ST_BAD_FREE  = 2'd3
    } status_t;

    typedef enum logic [0:0] {
        FUNC_ALLOC = 1'b0,
        FUNC_FREE  = 1'b1
    } func_t;

    typedef struct packed {
        logic [ORD_W-1:0] order;
        kind_t            kind;
    } entry_t;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN_RD,
        S_SCAN_CHK,
        S_SPLIT,
        S_FREE_CHK,
        S_MERGE_RD,
        S_MERGE_CHK,
        S_DONE
    } fsm_t;

endpackage

// ----- src/bpa_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module bpa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- src/buddy_page_allocator.sv -----
// Top level of the binary buddy page allocator with its sequencer.
//
//  channel   dir  ports                    payload
//  s_        in   tvalid/tready/tdata/user request_bytes, free_address; tuser func
//  m_        out  tvalid/tready/tdata/user block_address, block_order; tuser status
//
// Sequence: an allocate walks the block list with a read and a check state per
// block (up to 256 blocks), then one split state per order; a free reads and
// checks each buddy in turn. The simple dual-port page table (one read and one write a cycle) sets this.
// Reset: a clearing pass writes every page table entry; no request is
// taken meanwhile. The block takes one request at a time and holds the result
// in an output register until the m_ side takes the transfer.
module buddy_page_allocator (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // [20:0] request_bytes, [40:21] free_address, zero fill
    input  logic [0:0]  s_tuser,   // [0] func
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [19:0] block_address, [24:20] block_order, zero fill
    output logic [1:0]  m_tuser    // [1:0] status
);

    localparam int PW = bpa_pkg::PAGE_W;
    localparam int OW = bpa_pkg::ORD_W;

    bpa_pkg::fsm_t   state_reg, state_next;
    logic [PW:0]     p_reg, p_next;          // walk pointer, carries past the last page
    logic [PW-1:0]   pg_reg, pg_next;        // page of the block being worked on
    logic [OW-1:0]   best_reg, best_next;    // smallest fitting free order seen
    logic [PW-1:0]   bestp_reg, bestp_next;
    logic [OW-1:0]   want_reg, want_next;
    logic [OW-1:0]   ord_reg, ord_next;      // split or merge order
    logic [PW-1:0]   clr_reg, clr_next;
    logic            mvalid_reg, mvalid_next;
    logic [19:0]     addr_reg, addr_next;
    logic [4:0]      bord_reg, bord_next;
    bpa_pkg::status_t stat_reg, stat_next;

    logic            ram_we;
    logic [PW-1:0]   ram_waddr, ram_raddr;
    bpa_pkg::entry_t ram_wdata, rd;
    logic [$bits(bpa_pkg::entry_t)-1:0] ram_rdata;

    logic [20:0]     req;
    logic [19:0]     faddr;
    logic [OW-1:0]   want_c;
    logic            fits_c;
    logic [PW:0]     step_c;
    logic [PW:0]     sum_c;
    logic [PW-1:0]   buddy_c;
    logic [OW-1:0]   ord_clamp;

    bpa_ram #(.WIDTH($bits(bpa_pkg::entry_t)), .DEPTH(bpa_pkg::NPAGES)) u_table (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign rd    = bpa_pkg::entry_t'(ram_rdata);
    assign req   = s_tdata[20:0];
    assign faddr = s_tdata[40:21];

    // Round the byte request up to a page order; compares are independent.
    always_comb begin
        want_c = '0;
        fits_c = 1'b0;
        for (int k = 0; k <= bpa_pkg::TOP_ORDER; k++) begin
            if (!fits_c && ({1'b0, req} <= (22'(1) << (k + bpa_pkg::PAGE_SHIFT)))) begin
                want_c = OW'(k);
                fits_c = 1'b1;
            end
        end
    end

    // Walk stride: a non-head page advances by one, a head by its block size.
    assign ord_clamp = (rd.order > OW'(bpa_pkg::TOP_ORDER)) ? OW'(bpa_pkg::TOP_ORDER)
                                                            : rd.order;
    assign step_c = (rd.kind == bpa_pkg::KIND_NONE) ? (PW+1)'(1)
                                                    : ((PW+1)'(1) << ord_clamp);
    assign sum_c   = p_reg + step_c;
    assign buddy_c = pg_reg ^ (PW'(1) << ord_reg[2:0]);

    always_comb begin
        state_next  = state_reg;
        p_next      = p_reg;
        pg_next     = pg_reg;
        best_next   = best_reg;
        bestp_next  = bestp_reg;
        want_next   = want_reg;
        ord_next    = ord_reg;
        clr_next    = clr_reg;
        mvalid_next = mvalid_reg;
        addr_next   = addr_reg;
        bord_next   = bord_reg;
        stat_next   = stat_reg;
        ram_we      = 1'b0;
        ram_waddr   = pg_reg;
        ram_wdata   = '{order: '0, kind: bpa_pkg::KIND_NONE};
        ram_raddr   = p_reg[PW-1:0];
        s_tready    = 1'b0;

        case (state_reg)
            bpa_pkg::S_CLEAR: begin
                // Write the reset image: page zero one free region-sized block.
                ram_we    = 1'b1;
                ram_waddr = clr_reg;
                if (clr_reg == '0) begin
                    ram_wdata = '{order: OW'(bpa_pkg::TOP_ORDER), kind: bpa_pkg::KIND_FREE};
                end
                clr_next = clr_reg + PW'(1);
                if (clr_reg == PW'(bpa_pkg::NPAGES - 1)) begin
                    state_next = bpa_pkg::S_IDLE;
                end
            end
            bpa_pkg::S_IDLE: begin
                s_tready  = 1'b1;
                ram_raddr = faddr[19:bpa_pkg::PAGE_SHIFT];
                if (s_tvalid) begin
                    if (s_tuser[0] == bpa_pkg::FUNC_ALLOC) begin
                        want_next = want_c;
                        p_next    = '0;
                        best_next = '1;
                        if (!fits_c) begin
                            stat_next   = bpa_pkg::ST_TOO_LARGE;
                            addr_next   = '0;
                            bord_next   = '0;
                            mvalid_next = 1'b1;
                            state_next  = bpa_pkg::S_DONE;
                        end else begin
                            state_next = bpa_pkg::S_SCAN_RD;
                        end
                    end else begin
                        pg_next = faddr[19:bpa_pkg::PAGE_SHIFT];
                        if (faddr[bpa_pkg::PAGE_SHIFT-1:0] != '0) begin
                            stat_next   = bpa_pkg::ST_BAD_FREE;
                            addr_next   = '0;
                            bord_next   = '0;
                            mvalid_next = 1'b1;
                            state_next  = bpa_pkg::S_DONE;
                        end else begin
                            state_next = bpa_pkg::S_FREE_CHK;
                        end
                    end
                end
            end
            bpa_pkg::S_SCAN_RD: begin
                state_next = bpa_pkg::S_SCAN_CHK;
            end
            bpa_pkg::S_SCAN_CHK: begin
                // Keep the smallest fitting order; ascending walk keeps lowest address.
                if (rd.kind == bpa_pkg::KIND_FREE && rd.order >= want_reg &&
                    rd.order < best_reg) begin
                    best_next  = rd.order;
                    bestp_next = p_reg[PW-1:0];
                end
                p_next = sum_c;
                if (sum_c[PW]) begin
                    if (best_next == '1) begin
                        stat_next   = bpa_pkg::ST_NO_SPACE;
                        addr_next   = '0;
                        bord_next   = '0;
                        mvalid_next = 1'b1;
                        state_next  = bpa_pkg::S_DONE;
                    end else begin
                        pg_next    = bestp_next;
                        ord_next   = best_next;
                        state_next = bpa_pkg::S_SPLIT;
                    end
                end else begin
                    state_next = bpa_pkg::S_SCAN_RD;
                end
            end
            bpa_pkg::S_SPLIT: begin
                ram_we = 1'b1;
                if (ord_reg > want_reg) begin
                    // Upper half of the split goes back as a free block.
                    ram_waddr = pg_reg ^ (PW'(1) << 3'(ord_reg - OW'(1)));
                    ram_wdata = '{order: ord_reg - OW'(1), kind: bpa_pkg::KIND_FREE};
                    ord_next  = ord_reg - OW'(1);
                end else begin
                    ram_waddr   = pg_reg;
                    ram_wdata   = '{order: want_reg, kind: bpa_pkg::KIND_USED};
                    stat_next   = bpa_pkg::ST_OK;
                    addr_next   = {pg_reg, {bpa_pkg::PAGE_SHIFT{1'b0}}};
                    bord_next   = 5'(want_reg) + 5'(bpa_pkg::PAGE_SHIFT);
                    mvalid_next = 1'b1;
                    state_next  = bpa_pkg::S_DONE;
                end
            end
            bpa_pkg::S_FREE_CHK: begin
                if (rd.kind != bpa_pkg::KIND_USED) begin
                    stat_next   = bpa_pkg::ST_BAD_FREE;
                    addr_next   = '0;
                    bord_next   = '0;
                    mvalid_next = 1'b1;
                    state_next  = bpa_pkg::S_DONE;
                end else begin
                    ord_next   = ord_clamp;
                    state_next = bpa_pkg::S_MERGE_RD;
                end
            end
            bpa_pkg::S_MERGE_RD: begin
                ram_raddr = buddy_c;
                if (ord_reg < OW'(bpa_pkg::TOP_ORDER)) begin
                    state_next = bpa_pkg::S_MERGE_CHK;
                end else begin
                    ram_we      = 1'b1;
                    ram_wdata   = '{order: ord_reg, kind: bpa_pkg::KIND_FREE};
                    stat_next   = bpa_pkg::ST_OK;
                    addr_next   = {pg_reg, {bpa_pkg::PAGE_SHIFT{1'b0}}};
                    bord_next   = 5'(ord_reg) + 5'(bpa_pkg::PAGE_SHIFT);
                    mvalid_next = 1'b1;
                    state_next  = bpa_pkg::S_DONE;
                end
            end
            bpa_pkg::S_MERGE_CHK: begin
                ram_we = 1'b1;
                if (rd.kind == bpa_pkg::KIND_FREE && rd.order == ord_reg) begin
                    // Clear whichever head stops being a block start.
                    if (buddy_c < pg_reg) begin
                        ram_waddr = pg_reg;
                        pg_next   = buddy_c;
                    end else begin
                        ram_waddr = buddy_c;
                    end
                    ord_next   = ord_reg + OW'(1);
                    state_next = bpa_pkg::S_MERGE_RD;
                end else begin
                    ram_wdata   = '{order: ord_reg, kind: bpa_pkg::KIND_FREE};
                    stat_next   = bpa_pkg::ST_OK;
                    addr_next   = {pg_reg, {bpa_pkg::PAGE_SHIFT{1'b0}}};
                    bord_next   = 5'(ord_reg) + 5'(bpa_pkg::PAGE_SHIFT);
                    mvalid_next = 1'b1;
                    state_next  = bpa_pkg::S_DONE;
                end
            end
            bpa_pkg::S_DONE: begin
                if (m_tready) begin
                    mvalid_next = 1'b0;
                    state_next  = bpa_pkg::S_IDLE;
                end
            end
            default: begin
                state_next = bpa_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= bpa_pkg::S_CLEAR;
            clr_reg    <= '0;
            mvalid_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            clr_reg    <= clr_next;
            mvalid_reg <= mvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        p_reg     <= p_next;
        pg_reg    <= pg_next;
        best_reg  <= best_next;
        bestp_reg <= bestp_next;
        want_reg  <= want_next;
        ord_reg   <= ord_next;
        addr_reg  <= addr_next;
        bord_reg  <= bord_next;
        stat_reg  <= stat_next;
    end

    assign m_tvalid = mvalid_reg;
    assign m_tdata  = {7'd0, bord_reg, addr_reg};
    assign m_tuser  = stat_reg;

`ifndef NO_ASSERTIONS
    a_one_side: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_tready && m_tvalid))
        else $error("request taken while a result is pending");

    a_fail_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser != bpa_pkg::ST_OK |-> m_tdata == 32'd0)
        else $error("failed result carries nonzero fields");

    a_order_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == bpa_pkg::ST_OK |->
        m_tdata[24:20] >= 5'(bpa_pkg::PAGE_SHIFT) &&
        m_tdata[24:20] <= 5'(bpa_pkg::REGION_SHIFT))
        else $error("granted order out of range");

    a_clear_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == bpa_pkg::S_CLEAR |-> !s_tready && !m_tvalid)
        else $error("handshake active during clearing pass");
`endif

endmodule

// ----- sim/buddy_page_allocator_test.sv -----
// Testbench for the buddy page allocator: self-checking against an in-bench page table.
`timescale 1ns / 1ps

module buddy_page_allocator_test;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [47:0] s_tdata;   // [20:0] request_bytes, [40:21] free_address, zero fill
    logic [0:0]  s_tuser;   // [0] func
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;   // [19:0] block_address, [24:20] block_order, zero fill
    logic [1:0]  m_tuser;   // [1:0] status

    typedef struct packed {
        logic [19:0]      address;
        logic [4:0]       order;
        bpa_pkg::status_t status;
    } grant_t;

    // Expected results, oldest first.
    grant_t grants_due[$];

    // Shadow page table.
    logic [bpa_pkg::ORD_W-1:0] page_order[bpa_pkg::NPAGES];
    bpa_pkg::kind_t            page_kind[bpa_pkg::NPAGES];

    // Addresses of blocks held by the stimulus, for well-formed frees.
    logic [19:0] held_blocks[$];

    int errors;
    int cycles;
    int burst_left;
    int stall_mode;

    localparam int CYCLE_LIMIT = 4_000_000;

    buddy_page_allocator i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always begin
        aclk = 1'b1;
        #1;
        aclk = 1'b0;
        #1;
    end

    // Clear the shadow table to one free block spanning the region.
    task automatic table_reset();
        for (int p = 0; p < bpa_pkg::NPAGES; p++) begin
            page_order[p] = '0;
            page_kind[p]  = bpa_pkg::KIND_NONE;
        end
        page_order[0] = bpa_pkg::ORD_W'(bpa_pkg::TOP_ORDER);
        page_kind[0]  = bpa_pkg::KIND_FREE;
    endtask

    // Lowest-address free head of order k, or NPAGES when there is none.
    function automatic int lowest_free(int k);
        for (int p = 0; p < bpa_pkg::NPAGES; p++)
            if (page_kind[p] == bpa_pkg::KIND_FREE && page_order[p] == k) return p;
        return bpa_pkg::NPAGES;
    endfunction

    // Grant a block: round up to an order, pick the smallest free block, split it.
    function automatic grant_t grant_block(logic [20:0] req);
        grant_t g;
        int want;
        int k;
        int p;
        int b;
        g = '0;
        want = -1;
        for (int i = 0; i <= bpa_pkg::TOP_ORDER; i++)
            if (want < 0 && 64'(req) <= (64'd1 << (i + bpa_pkg::PAGE_SHIFT))) want = i;
        if (want < 0) begin
            g.status = bpa_pkg::ST_TOO_LARGE;
            return g;
        end
        p = bpa_pkg::NPAGES;
        k = want;
        while (k <= bpa_pkg::TOP_ORDER) begin
            p = lowest_free(k);
            if (p < bpa_pkg::NPAGES) break;
            k++;
        end
        if (p >= bpa_pkg::NPAGES) begin
            g.status = bpa_pkg::ST_NO_SPACE;
            return g;
        end
        for (int i = k; i > want; i--) begin
            b = (p ^ (1 << (i - 1))) & (bpa_pkg::NPAGES - 1);
            page_order[b] = bpa_pkg::ORD_W'(i - 1);
            page_kind[b]  = bpa_pkg::KIND_FREE;
        end
        page_order[p] = bpa_pkg::ORD_W'(want);
        page_kind[p]  = bpa_pkg::KIND_USED;
        g.address = 20'(p << bpa_pkg::PAGE_SHIFT);
        g.order   = 5'(want + bpa_pkg::PAGE_SHIFT);
        g.status  = bpa_pkg::ST_OK;
        return g;
    endfunction

    // Release a block and merge it with free buddies as far as possible.
    function automatic grant_t release_block(logic [19:0] addr);
        grant_t g;
        int p;
        int o;
        int b;
        g = '0;
        p = int'(addr >> bpa_pkg::PAGE_SHIFT);
        if (addr[bpa_pkg::PAGE_SHIFT-1:0] != 0 || p >= bpa_pkg::NPAGES ||
            page_kind[p] != bpa_pkg::KIND_USED) begin
            g.status = bpa_pkg::ST_BAD_FREE;
            return g;
        end
        o = page_order[p];
        if (o > bpa_pkg::TOP_ORDER) o = bpa_pkg::TOP_ORDER;
        page_kind[p] = bpa_pkg::KIND_NONE;
        while (o < bpa_pkg::TOP_ORDER) begin
            b = (p ^ (1 << o)) & (bpa_pkg::NPAGES - 1);
            if (page_kind[b] != bpa_pkg::KIND_FREE || page_order[b] != o) break;
            page_kind[b]  = bpa_pkg::KIND_NONE;
            page_order[b] = '0;
            if (b < p) begin
                page_kind[p]  = bpa_pkg::KIND_NONE;
                page_order[p] = '0;
                p = b;
            end
            o++;
        end
        page_order[p] = bpa_pkg::ORD_W'(o);
        page_kind[p]  = bpa_pkg::KIND_FREE;
        g.address = 20'(p << bpa_pkg::PAGE_SHIFT);
        g.order   = 5'(o + bpa_pkg::PAGE_SHIFT);
        g.status  = bpa_pkg::ST_OK;
        return g;
    endfunction

    // Send one request in a transfer, predicting its result on acceptance.
    task automatic send_request(bpa_pkg::func_t fn, logic [20:0] req, logic [19:0] addr);
        grant_t g;
        // Hold off between bursts.
        if (burst_left == 0) begin
            repeat ($urandom_range(0, 3) == 0 ? $urandom_range(1, 12) : 0)
                @(negedge aclk);
            burst_left = $urandom_range(1, 16);
        end
        burst_left--;
        s_tvalid = 1'b1;
        s_tuser  = fn;
        s_tdata  = {7'd0, addr, req};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        if (fn == bpa_pkg::FUNC_ALLOC) begin
            g = grant_block(req);
            if (g.status == bpa_pkg::ST_OK) held_blocks.push_back(g.address);
        end else begin
            g = release_block(addr);
        end
        grants_due.push_back(g);
        @(negedge aclk);
        s_tvalid = 1'b0;
    endtask

    task automatic alloc_bytes(logic [20:0] req);
        send_request(bpa_pkg::FUNC_ALLOC, req, 20'($urandom));
    endtask

    task automatic free_addr(logic [19:0] addr);
        send_request(bpa_pkg::FUNC_FREE, 21'($urandom), addr);
    endtask

    // Free a random held block.
    task automatic free_held();
        int idx;
        logic [19:0] a;
        idx = $urandom_range(0, held_blocks.size() - 1);
        a = held_blocks[idx];
        held_blocks.delete(idx);
        free_addr(a);
    endtask

    // Compare each result transfer with the oldest expectation.
    always @(posedge aclk) begin
        grant_t g;
        if (aresetn && m_tvalid && m_tready) begin
            if (grants_due.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected result tdata=%h tuser=%h",
                                           m_tdata, m_tuser);
            end else begin
                g = grants_due.pop_front();
                if (m_tdata[19:0] !== g.address || m_tdata[24:20] !== g.order ||
                    m_tdata[31:25] !== 7'd0 || m_tuser !== g.status) begin
                    errors++;
                    if (errors <= 10)
                        $display({"mismatch: exp addr=%h ord=%0d st=%0d ",
                                  "got addr=%h ord=%0d st=%0d"},
                                 g.address, g.order, g.status, m_tdata[19:0],
                                 m_tdata[24:20], m_tuser);
                end
            end
        end
    end

    // Receiver back-pressure: cycle among always ready, random, and long stalls.
    always @(negedge aclk) begin
        if (cycles % 500 == 0) stall_mode = $urandom_range(0, 2);
        case (stall_mode)
            0: m_tready <= 1'b1;
            1: m_tready <= ($urandom_range(0, 1) == 1);
            default: m_tready <= ($urandom_range(0, 7) == 0);
        endcase
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Every order, size extremes, full region, exhaustion and merges back.
    task automatic test_directed();
        alloc_bytes(21'd0);
        alloc_bytes(21'd1);
        alloc_bytes(21'd4096);
        alloc_bytes(21'd4097);
        alloc_bytes(21'd1048577);
        alloc_bytes(21'h1FFFFF);
        for (int o = 14; o <= 19; o++) alloc_bytes(21'(1 << o));
        alloc_bytes(21'd1048576);
        free_addr(20'h00001);
        free_addr(20'hFF000);
        free_addr(20'hFFFFF);
        while (held_blocks.size() > 0) free_held();
        free_addr(20'h00000);
        alloc_bytes(21'd1048576);
        alloc_bytes(21'd0);
        while (held_blocks.size() > 0) free_held();
    endtask

    // Mostly alloc/free of held blocks, with some bad frees and oversize asks.
    task automatic test_random();
        int sel;
        for (int n = 0; n < 1000; n++) begin
            sel = $urandom_range(0, 99);
            if (sel < 4) begin
                free_addr(20'($urandom));
            end else if (sel < 7) begin
                alloc_bytes(21'($urandom_range(1048577, 2097151)));
            end else if (sel < 55 || held_blocks.size() == 0) begin
                // Bias toward small sizes, with the full range now and then.
                case ($urandom_range(0, 3))
                    0: alloc_bytes(21'($urandom_range(0, 8192)));
                    1: alloc_bytes(21'($urandom_range(0, 65536)));
                    2: alloc_bytes(21'(1 << $urandom_range(12, 20)));
                    default: alloc_bytes(21'($urandom_range(0, 1048576)));
                endcase
            end else begin
                free_held();
            end
        end
        while (held_blocks.size() > 0) free_held();
    endtask

    initial begin
        errors     = 0;
        cycles     = 0;
        burst_left = 0;
        stall_mode = 0;
        aresetn    = 1'b0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        s_tuser    = '0;
        m_tready   = 1'b0;
        table_reset();
        repeat (3) @(negedge aclk);
        aresetn <= 1'b1;

        test_directed();
        test_random();

        while (grants_due.size() != 0) @(posedge aclk);
        repeat (50) @(posedge aclk);
        if (errors == 0 && grants_due.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
